// ===== rtl/core/bfra_pkg.sv =====
`default_nettype none
package bfra_pkg;

  localparam int unsigned PAGE_W = 36;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_ALLOCATE = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } result_code_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PAGE_W-1:0] region_page;
    logic [PAGE_W-1:0] page_count;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] granted_page;
    logic [6:0]        entries_used;
  } response_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD     = 4'd1,  // latch the request, reset the scan index
    OP_SCAN_FIT = 4'd2,  // look for first entry with pages >= key
    OP_SCAN_HLD = 4'd3,  // look for entry holding addr
    OP_TAKE     = 4'd4,  // latch the found entry, start drop shift
    OP_DROP     = 4'd5,  // shift one entry down
    OP_PUTSCAN  = 4'd6,  // find insert position for pending piece
    OP_PUTSHIFT = 4'd7,  // shift one entry up, or write the piece
    OP_ALLOCSET = 4'd8,  // record grant and prepare remainder piece
    OP_REMSET   = 4'd9,  // prepare prefix piece
    OP_SUFSET   = 4'd10, // prepare suffix piece
    OP_ADVANCE  = 4'd11  // continue removal at old end
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;   // scan index reached used count
    logic scan_hit;    // current entry matches
    logic rd_valid;    // read data of current index is registered
    logic shift_done;  // shift reached its target
    logic full;        // table full
    logic has_rem;     // allocate remainder non-empty
    logic has_prefix;  // removal prefix non-empty
    logic sfx_more;    // cend > end
    logic sfx_equal;   // cend == end
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfra_datapath.sv =====
`default_nettype none
module bfra_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES),
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bfra_pkg::dp_cmd_t            dp_cmd,
  input  wire bfra_pkg::request_t           req,
  output      bfra_pkg::dp_status_t         dp_status,
  output      logic [bfra_pkg::PAGE_W-1:0]  granted,
  output      logic [CNT_W-1:0]             used_count
);

  localparam int unsigned PW = bfra_pkg::PAGE_W;

  logic [PW-1:0] mem_start [TABLE_ENTRIES];
  logic [PW-1:0] mem_pages [TABLE_ENTRIES];

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  logic [PW-1:0]    rd_start, rd_pages;
  logic             rd_valid;
  logic [PW:0]      addr;
  logic [PW-1:0]    key, end_pg;
  logic             end_c;
  logic [PW-1:0]    t_start, t_pages;
  logic [PW-1:0]    p_start, p_pages;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [PW-1:0]    wr_start, wr_pages;

  logic [PW:0]      rd_end, t_end;

  assign rd_end = {1'b0, rd_start} + {1'b0, rd_pages};
  assign t_end  = {1'b0, t_start} + {1'b0, t_pages};

  // Read address per operation: scans read idx, shifts read neighbour.
  always_comb begin
    rd_addr = idx[IDX_W-1:0];
    wr_en = 1'b0;
    wr_addr = idx[IDX_W-1:0];
    wr_start = rd_start;
    wr_pages = rd_pages;
    unique case (dp_cmd.op)
      bfra_pkg::OP_DROP: begin
        rd_addr = IDX_W'(idx + 1'b1);
        wr_en = rd_valid;
      end
      bfra_pkg::OP_PUTSHIFT: begin
        rd_addr = IDX_W'(idx - 1'b1);
        if (idx == pos) begin
          wr_en = 1'b1;
          wr_start = p_start;
          wr_pages = p_pages;
        end else begin
          wr_en = rd_valid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_start <= mem_start[rd_addr];
    rd_pages <= mem_pages[rd_addr];
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_pages[wr_addr] <= wr_pages;
    end
  end

  always_comb begin
    dp_status.scan_done  = (idx >= used_count);
    if (dp_cmd.op == bfra_pkg::OP_SCAN_FIT) begin
      dp_status.scan_hit = (key <= rd_pages);
    end else if (dp_cmd.op == bfra_pkg::OP_PUTSCAN) begin
      dp_status.scan_hit = (p_pages <= rd_pages);
    end else begin
      dp_status.scan_hit = ({1'b0, rd_start} <= addr) && (addr < rd_end);
    end
    dp_status.rd_valid   = rd_valid;
    dp_status.shift_done = (dp_cmd.op == bfra_pkg::OP_DROP)
                           ? (CNT_W'(idx + 1'b1) >= used_count) : (idx == pos);
    dp_status.full       = (used_count >= CNT_W'(TABLE_ENTRIES));
    dp_status.has_rem    = (t_pages > key);
    dp_status.has_prefix = ({1'b0, t_start} < addr);
    dp_status.sfx_more   = (t_end > {end_c, end_pg});
    dp_status.sfx_equal  = (t_end == {end_c, end_pg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      unique case (dp_cmd.op)
        bfra_pkg::OP_LOAD: begin
          addr <= {1'b0, req.region_page[PW-1:0]};
          key <= req.page_count[PW-1:0];
          {end_c, end_pg} <= {1'b0, req.region_page[PW-1:0]}
                           + {1'b0, req.page_count[PW-1:0]};
          p_start <= req.region_page[PW-1:0];
          p_pages <= req.page_count[PW-1:0];
          granted <= '0;
          idx <= '0;
        end
        bfra_pkg::OP_SCAN_FIT, bfra_pkg::OP_SCAN_HLD, bfra_pkg::OP_PUTSCAN: begin
          // Advance only once registered read data has been compared.
          if (idx >= used_count) begin
            pos <= idx;
          end else if (!rd_valid) begin
            rd_valid <= 1'b1;
          end else if (!dp_status.scan_hit) begin
            idx <= CNT_W'(idx + 1'b1);
          end else begin
            pos <= idx;
            // Putscan starts its shift from the top of the table.
            if (dp_cmd.op == bfra_pkg::OP_PUTSCAN) idx <= used_count;
          end
        end
        bfra_pkg::OP_TAKE: begin
          t_start <= rd_start;
          t_pages <= rd_pages;
        end
        bfra_pkg::OP_DROP: begin
          if (CNT_W'(idx + 1'b1) >= used_count) begin
            used_count <= CNT_W'(used_count - 1'b1);
            idx <= '0;
          end else if (rd_valid) begin
            idx <= CNT_W'(idx + 1'b1);
          end else begin
            rd_valid <= 1'b1;
          end
        end
        bfra_pkg::OP_PUTSHIFT: begin
          if (idx == pos) begin
            used_count <= CNT_W'(used_count + 1'b1);
            idx <= '0;
          end else if (rd_valid) begin
            idx <= CNT_W'(idx - 1'b1);
          end else begin
            rd_valid <= 1'b1;
          end
        end
        bfra_pkg::OP_ALLOCSET: begin
          granted <= t_start;
          p_start <= t_start + key;
          p_pages <= t_pages - key;
          idx <= '0;
        end
        bfra_pkg::OP_REMSET: begin
          p_start <= t_start;
          p_pages <= PW'(addr - {1'b0, t_start});
          idx <= '0;
        end
        bfra_pkg::OP_SUFSET: begin
          p_start <= end_pg;
          p_pages <= PW'(t_end - {end_c, end_pg});
          idx <= '0;
        end
        bfra_pkg::OP_ADVANCE: begin
          addr <= t_end;
          idx <= '0;
        end
        default: begin
          if (dp_cmd.op == bfra_pkg::OP_NOP) idx <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bfra_ctrl.sv =====
`default_nettype none
module bfra_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           cmd,
  input  wire bfra_pkg::dp_status_t dp_status,
  output      bfra_pkg::dp_cmd_t    dp_cmd,
  output      logic                 busy,
  output      logic                 done,
  output      logic [1:0]           status
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LOAD   = 11'b00000000010,
    S_FIT    = 11'b00000000100,
    S_HOLD   = 11'b00000001000,
    S_TAKE   = 11'b00000010000,
    S_DROP   = 11'b00000100000,
    S_AFTER  = 11'b00001000000,
    S_PSCAN  = 11'b00010000000,
    S_PSHIFT = 11'b00100000000,
    S_SUFFIX = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  // Where a completed put returns to.
  typedef enum logic [1:0] {
    RET_DONE = 2'd0,
    RET_SUF  = 2'd1
  } ret_t;

  state_t state, state_next;
  logic [1:0] op_cmd, op_cmd_next;
  logic [1:0] st, st_next;
  ret_t ret, ret_next;
  logic hold_cmp;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign status = st;

  always_comb begin
    state_next = state;
    op_cmd_next = op_cmd;
    st_next = st;
    ret_next = ret;
    dp_cmd.op = bfra_pkg::OP_NOP;
    hold_cmp = dp_status.rd_valid;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          // Latch the request at the accepting edge.
          dp_cmd.op = bfra_pkg::OP_LOAD;
          op_cmd_next = cmd;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        st_next = bfra_pkg::ST_OK;
        ret_next = RET_DONE;
        unique case (op_cmd)
          bfra_pkg::CMD_INSERT: state_next = S_PSCAN;
          bfra_pkg::CMD_ALLOCATE: state_next = S_FIT;
          bfra_pkg::CMD_REMOVE: state_next = S_HOLD;
          default: begin
            st_next = bfra_pkg::ST_NOFIT;
            state_next = S_DONE;
          end
        endcase
      end
      S_FIT, S_HOLD: begin
        dp_cmd.op = (state == S_FIT) ? bfra_pkg::OP_SCAN_FIT : bfra_pkg::OP_SCAN_HLD;
        if (dp_status.scan_done) begin
          st_next = bfra_pkg::ST_NOFIT;
          state_next = S_DONE;
        end else if (hold_cmp && dp_status.scan_hit) begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        dp_cmd.op = bfra_pkg::OP_TAKE;
        state_next = S_DROP;
      end
      S_DROP: begin
        dp_cmd.op = bfra_pkg::OP_DROP;
        if (dp_status.shift_done) state_next = S_AFTER;
      end
      S_AFTER: begin
        if (op_cmd == bfra_pkg::CMD_ALLOCATE) begin
          dp_cmd.op = bfra_pkg::OP_ALLOCSET;
          ret_next = RET_DONE;
          state_next = dp_status.has_rem ? S_PSCAN : S_DONE;
        end else if (dp_status.has_prefix) begin
          dp_cmd.op = bfra_pkg::OP_REMSET;
          ret_next = RET_SUF;
          state_next = S_PSCAN;
        end else begin
          state_next = S_SUFFIX;
        end
      end
      S_PSCAN: begin
        dp_cmd.op = bfra_pkg::OP_PUTSCAN;
        if (dp_status.full) begin
          st_next = bfra_pkg::ST_FULL;
          state_next = S_DONE;
        end else if (dp_status.scan_done
                     || (dp_status.rd_valid && dp_status.scan_hit)) begin
          state_next = S_PSHIFT;
        end
      end
      S_PSHIFT: begin
        dp_cmd.op = bfra_pkg::OP_PUTSHIFT;
        if (dp_status.shift_done) begin
          state_next = (ret == RET_SUF) ? S_SUFFIX : S_DONE;
        end
      end
      S_SUFFIX: begin
        ret_next = RET_DONE;
        if (dp_status.sfx_more) begin
          dp_cmd.op = bfra_pkg::OP_SUFSET;
          state_next = S_PSCAN;
        end else if (dp_status.sfx_equal) begin
          state_next = S_DONE;
        end else begin
          dp_cmd.op = bfra_pkg::OP_ADVANCE;
          state_next = S_HOLD;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_cmd <= bfra_pkg::CMD_NONE;
      st <= bfra_pkg::ST_OK;
      ret <= RET_DONE;
    end else begin
      state <= state_next;
      op_cmd <= op_cmd_next;
      st <= st_next;
      ret <= ret_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/best_fit_region_allocator.sv =====
`default_nettype none
// The block takes one command at a time, accepted only while busy is low; each result
// shows for one cycle with done high, and the receiver cannot stall. Scan, drop and put
// passes walk the region table memory entry by entry, and a remove repeats its passes for
// each further region it spans. A put into a full table ends the command with ST_FULL.
// Synchronous reset empties the table.
module best_fit_region_allocator #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire bfra_pkg::request_t  req,
  output      logic                busy,
  output      logic                done,
  output      bfra_pkg::response_t rsp
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  bfra_pkg::dp_cmd_t    dp_cmd;
  bfra_pkg::dp_status_t dp_status;
  logic [bfra_pkg::PAGE_W-1:0] granted;
  logic [CNT_W-1:0] used_count;
  logic [1:0] status;

  // Controller: sequence scan, drop and put passes for each transfer.
  bfra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cmd(req.cmd),
    .dp_status(dp_status), .dp_cmd(dp_cmd),
    .busy(busy), .done(done), .status(status)
  );

  // Datapath: hold the table memory and the working registers.
  bfra_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk(clk), .rst(rst), .dp_cmd(dp_cmd), .req(req),
    .dp_status(dp_status), .granted(granted), .used_count(used_count)
  );

  // Drive the response; fields are only meaningful while done is high.
  always_comb begin
    rsp.status = status;
    rsp.granted_page = granted;
    rsp.entries_used = 7'(used_count);
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(TABLE_ENTRIES))
    else $error("used count beyond table size");

endmodule
`default_nettype wire
